[hdl/gpg_pkg.sv]
// ----------------------------------------------------------------------------
// Glyph pixel generator package
// Shared beat types, controller states, command and status bundles, and the
// 5x7 font table.
// ----------------------------------------------------------------------------
`default_nettype none

package gpg_pkg;

  localparam int unsigned ColorBits  = 16;
  localparam int unsigned OffsetBits = 20;
  localparam int unsigned CoordBits  = 12;
  localparam int unsigned DimBits    = 11;

  localparam logic [7:0] GlyphFirst = 8'd32;
  localparam logic [7:0] GlyphLast  = 8'd126;
  localparam logic [2:0] LastCol    = 3'd4;
  localparam logic [3:0] RowsNormal = 4'd8;
  localparam logic [3:0] RowsItalic = 4'd9;
  localparam logic [11:0] CellSpan  = 12'd9;

  localparam logic [DimBits-1:0] DimMin      = 11'd16;
  localparam logic [DimBits-1:0] WidthReset  = 11'd480;
  localparam logic [DimBits-1:0] HeightReset = 11'd272;

  localparam logic CfgScreenWidth  = 1'b0;
  localparam logic CfgScreenHeight = 1'b1;

  typedef struct packed {
    logic signed [CoordBits-1:0] x_pos;
    logic signed [CoordBits-1:0] y_pos;
    logic [7:0]                  char_code;
    logic [ColorBits-1:0]        fg_color;
    logic [ColorBits-1:0]        bg_color;
    logic                        italic;
  } in_beat_t;

  typedef struct packed {
    logic [OffsetBits-1:0] pixel_offset;
    logic [ColorBits-1:0]  pixel_color;
    logic                  last;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } ctl_state_e;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
  } gpg_cmd_t;

  typedef struct packed {
    logic fit;
    logic last_pix;
    logic out_free;
  } gpg_sts_t;

  typedef logic [0:4][7:0] glyph_t;

  function automatic glyph_t font_glyph(input logic [6:0] idx);
    glyph_t g;
    unique case (idx)
      7'd0:  g = 40'h0000000000;
      7'd1:  g = 40'h00005F0000;
      7'd2:  g = 40'h0007000700;
      7'd3:  g = 40'h147F147F14;
      7'd4:  g = 40'h242A7F2A12;
      7'd5:  g = 40'h2313086462;
      7'd6:  g = 40'h3649552250;
      7'd7:  g = 40'h0005030000;
      7'd8:  g = 40'h001C224100;
      7'd9:  g = 40'h0041221C00;
      7'd10: g = 40'h14083E0814;
      7'd11: g = 40'h08083E0808;
      7'd12: g = 40'h0050300000;
      7'd13: g = 40'h0808080808;
      7'd14: g = 40'h0060600000;
      7'd15: g = 40'h2010080402;
      7'd16: g = 40'h3E5149453E;
      7'd17: g = 40'h00427F4000;
      7'd18: g = 40'h4261514946;
      7'd19: g = 40'h2141454B31;
      7'd20: g = 40'h1814127F10;
      7'd21: g = 40'h2745454539;
      7'd22: g = 40'h3C4A494930;
      7'd23: g = 40'h0171090503;
      7'd24: g = 40'h3649494936;
      7'd25: g = 40'h064949291E;
      7'd26: g = 40'h0036360000;
      7'd27: g = 40'h0056360000;
      7'd28: g = 40'h0814224100;
      7'd29: g = 40'h1414141414;
      7'd30: g = 40'h0041221408;
      7'd31: g = 40'h0201510906;
      7'd32: g = 40'h324979413E;
      7'd33: g = 40'h7E1111117E;
      7'd34: g = 40'h7F49494936;
      7'd35: g = 40'h3E41414122;
      7'd36: g = 40'h7F4141221C;
      7'd37: g = 40'h7F49494941;
      7'd38: g = 40'h7F09090901;
      7'd39: g = 40'h3E4149497A;
      7'd40: g = 40'h7F0808087F;
      7'd41: g = 40'h00417F4100;
      7'd42: g = 40'h2040413F01;
      7'd43: g = 40'h7F08142241;
      7'd44: g = 40'h7F40404040;
      7'd45: g = 40'h7F020C027F;
      7'd46: g = 40'h7F0408107F;
      7'd47: g = 40'h3E4141413E;
      7'd48: g = 40'h7F09090906;
      7'd49: g = 40'h3E4151215E;
      7'd50: g = 40'h7F09192946;
      7'd51: g = 40'h4649494931;
      7'd52: g = 40'h01017F0101;
      7'd53: g = 40'h3F4040403F;
      7'd54: g = 40'h1F2040201F;
      7'd55: g = 40'h3F4038403F;
      7'd56: g = 40'h6314081463;
      7'd57: g = 40'h0708700807;
      7'd58: g = 40'h6151494543;
      7'd59: g = 40'h007F414100;
      7'd60: g = 40'h0204081020;
      7'd61: g = 40'h0041417F00;
      7'd62: g = 40'h0402010204;
      7'd63: g = 40'h4040404040;
      7'd64: g = 40'h0001020400;
      7'd65: g = 40'h2054545478;
      7'd66: g = 40'h7F48444438;
      7'd67: g = 40'h3844444420;
      7'd68: g = 40'h384444487F;
      7'd69: g = 40'h3854545418;
      7'd70: g = 40'h087E090102;
      7'd71: g = 40'h0C5252523E;
      7'd72: g = 40'h7F08040478;
      7'd73: g = 40'h00447D4000;
      7'd74: g = 40'h2040443D00;
      7'd75: g = 40'h7F10284400;
      7'd76: g = 40'h00417F4000;
      7'd77: g = 40'h7C04180478;
      7'd78: g = 40'h7C08040478;
      7'd79: g = 40'h3844444438;
      7'd80: g = 40'h7C14141408;
      7'd81: g = 40'h081414187C;
      7'd82: g = 40'h7C08040408;
      7'd83: g = 40'h4854545420;
      7'd84: g = 40'h043F444020;
      7'd85: g = 40'h3C4040207C;
      7'd86: g = 40'h1C2040201C;
      7'd87: g = 40'h3C4030403C;
      7'd88: g = 40'h4428102844;
      7'd89: g = 40'h0C5050503C;
      7'd90: g = 40'h4464544C44;
      7'd91: g = 40'h0008364100;
      7'd92: g = 40'h00007F0000;
      7'd93: g = 40'h0041360800;
      7'd94: g = 40'h1008081008;
      default: g = 40'h0000000000;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

[hdl/gpg_datapath.sv]
// ----------------------------------------------------------------------------
// Glyph pixel generator datapath
// Holds the screen size registers, the captured character beat, the glyph
// columns, the pixel counters and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gpg_datapath
  import gpg_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [DimBits-1:0]  cfg_data_i,
  input  wire in_beat_t            in_beat_i,
  input  wire gpg_cmd_t            cmd_i,
  output gpg_sts_t                 sts_o,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output out_beat_t                out_beat_o
);

  localparam logic [12:0] MaxWidthL  = 13'(MAX_WIDTH);
  localparam logic [12:0] MaxHeightL = 13'(MAX_HEIGHT);

  logic [DimBits-1:0]    width_q, height_q;
  logic [DimBits-1:0]    clamp_w, clamp_h;
  logic [12:0]           cfg_wide;
  in_beat_t              item_q;
  glyph_t                glyph_q;
  logic [OffsetBits-1:0] row_base_q, row_base_d;
  logic [2:0]            col_q, col_d;
  logic [3:0]            row_q, row_d;
  logic                  out_valid_q;
  out_beat_t             out_beat_q;
  logic [11:0]           x_u, y_u, x_end, y_end;
  logic [3:0]            rows;
  logic [22:0]           prod;
  logic [OffsetBits-1:0] row_start, stride;
  logic [6:0]            glyph_idx;
  logic                  pix_bit;
  logic                  last_pix;

  assign cfg_wide = {2'b00, cfg_data_i};
  assign clamp_w  = (cfg_data_i < DimMin) ? DimMin :
                    (cfg_wide > MaxWidthL) ? MaxWidthL[DimBits-1:0] : cfg_data_i;
  assign clamp_h  = (cfg_data_i < DimMin) ? DimMin :
                    (cfg_wide > MaxHeightL) ? MaxHeightL[DimBits-1:0] : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgScreenWidth:  width_q  <= clamp_w;
        CfgScreenHeight: height_q <= clamp_h;
        default: ;
      endcase
    end
  end

  assign x_u   = item_q.x_pos;
  assign y_u   = item_q.y_pos;
  assign rows  = item_q.italic ? RowsItalic : RowsNormal;
  assign x_end = x_u + CellSpan;
  assign y_end = y_u + 12'(rows);

  assign sts_o.fit = !x_u[11] && !y_u[11] &&
                     (x_end <= {1'b0, width_q}) && (y_end <= {1'b0, height_q});

  assign prod      = 23'(y_u) * 23'(width_q);
  assign row_start = prod[OffsetBits-1:0] + OffsetBits'(x_u);
  assign stride    = OffsetBits'(width_q) - OffsetBits'(item_q.italic);

  assign glyph_idx = ((item_q.char_code < GlyphFirst) || (item_q.char_code > GlyphLast)) ?
                     7'd0 : 7'(item_q.char_code - GlyphFirst);

  assign pix_bit  = row_q[3] ? 1'b0 : glyph_q[col_q][row_q[2:0]];
  assign last_pix = (row_q == rows - 4'd1) && (col_q == LastCol);

  always_comb begin
    row_base_d = row_base_q;
    col_d      = col_q;
    row_d      = row_q;
    if (cmd_i.setup) begin
      row_base_d = row_start;
      col_d      = 3'd0;
      row_d      = 4'd0;
    end else if (cmd_i.step) begin
      if (col_q == LastCol) begin
        col_d      = 3'd0;
        row_d      = row_q + 4'd1;
        row_base_d = row_base_q + stride;
      end else begin
        col_d = col_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_beat_i;
    end
    if (cmd_i.setup) begin
      glyph_q <= font_glyph(glyph_idx);
    end
    row_base_q <= row_base_d;
    col_q      <= col_d;
    row_q      <= row_d;
    if (cmd_i.step) begin
      out_beat_q.pixel_offset <= row_base_q + OffsetBits'(col_q);
      out_beat_q.pixel_color  <= pix_bit ? item_q.fg_color : item_q.bg_color;
      out_beat_q.last         <= last_pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.last_pix = last_pix;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

`default_nettype wire

[hdl/gpg_controller.sv]
// ----------------------------------------------------------------------------
// Glyph pixel generator controller
// Sequences one character: capture, bound check and setup, then one pixel
// beat per cycle whenever the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module gpg_controller
  import gpg_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire gpg_sts_t sts_i,
  output gpg_cmd_t      cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = sts_i.fit ? ST_RUN : ST_IDLE;
      end
      ST_RUN: begin
        if (sts_i.out_free) begin
          cmd_o.step = 1'b1;
          if (sts_i.last_pix) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[hdl/glyph_pixel_generator_unit.sv]
// ----------------------------------------------------------------------------
// Glyph pixel generator
// Renders one 5x7 font character cell into linear frame buffer pixel writes.
// ----------------------------------------------------------------------------
// Each input beat is one character cell. The unit captures it, then does the
// bound check, glyph fetch and row offset multiply in the setup state, then
// gives one pixel beat per cycle whenever the output register is free, for
// 40 pixels in normal mode or 45 in italic mode, set by the row and column
// counters that walk the cell. A cell that does not fit on the screen gives
// no pixel beats and frees the input again after the setup state. The output
// register lets the next cell be captured while the final pixel beat still
// waits. Screen size writes are stored already limited to 16 up to MAX_WIDTH or MAX_HEIGHT.
`default_nettype none

module glyph_pixel_generator_unit
  import gpg_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic [DimBits-1:0] cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_beat_t           in_beat_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_beat_t               out_beat_o
);

  gpg_cmd_t cmd;
  gpg_sts_t sts;

  gpg_controller u_ctl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gpg_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_beat_i   (in_beat_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire
